// ----- design/pssi_pkg.sv -----
// pssi_pkg: shared types and constants for the pair-sum index search block.
// Word structs for both channels, result status codes, sequencer states.
// No dependencies.
package pssi_pkg;

	localparam int VALUE_BITS    = 32;
	localparam int MAX_ITEMS_DEF = 256;

	typedef enum logic [2:0] {
		ST_NONE    = 3'd0,
		ST_PAIR    = 3'd1,
		ST_IGNORED = 3'd2,
		ST_OVER    = 3'd3,
		ST_END     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_HOLD
	} seq_state_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] item_value;
		logic                         first_of_set;
		logic                         last_of_set;
	} pssi_in_t;

	typedef struct packed {
		status_t                      status;
		logic [7:0]                   earlier_index;
		logic [7:0]                   current_index;
		logic signed [VALUE_BITS-1:0] partner_value;
		logic signed [VALUE_BITS-1:0] current_value;
	} pssi_out_t;

endpackage

// ----- design/pssi_store.sv -----
// pssi_store: value memory of the current set with one registered read port
// and the shared equality compare against the wanted partner value.
// Depends on pssi_pkg.
module pssi_store
	import pssi_pkg::*;
#(
	parameter int DEPTH = MAX_ITEMS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         scan_start,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic signed [VALUE_BITS-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	input  logic [VALUE_BITS:0]          need,
	output logic                         rd_vld,
	output logic [AW-1:0]                rd_idx,
	output logic signed [VALUE_BITS-1:0] rd_data,
	output logic                         match
);

	logic [VALUE_BITS-1:0] mem [DEPTH];
	logic [VALUE_BITS-1:0] rd_data_s1;
	logic [AW-1:0]         rd_addr_s1;
	logic                  rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else if (scan_start) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	// stored words are sign-extended by one bit to meet the wide difference
	assign match   = ({rd_data_s1[VALUE_BITS-1], rd_data_s1} == need);
	assign rd_vld  = rd_vld_s1;
	assign rd_idx  = rd_addr_s1;
	assign rd_data = rd_data_s1;

endmodule

// ----- design/pair_sum_index_search.sv -----
// pair_sum_index_search: streaming two-sum search over sets of values.
// Input channel item_valid/item_ready/item carries one value of a set per word;
// output channel result_valid/result_ready/result returns one word per item.
// cfg_we/cfg_wdata write target_sum; it is the user's duty to write only while the block is idle.
// Each scanned item computes target_sum - value one bit wider than the data,
// then walks the earlier values of its set from newest to oldest, one memory
// read per cycle, and stops at the first match. A miss stores the value at
// the slot of its index; a hit reports both indices and values and the rest
// of the set is answered as ignored. Items past MAX_ITEMS are flagged.
// Ignored and over-capacity items skip the scan. The scan is paced by the
// single read port of the value memory, scanned one entry a cycle. One item is
// in work at a time; item_ready is high only when idle, from the cycle after
// the last result is loaded.
// The result sits in an output register, so a new item is taken while the
// previous result waits; a result that finds that register still full holds
// the sequencer until the receiver takes the word.
// Reset: target_sum is 0, the set is empty, no result is pending. No
// clearing pass is needed; slots below the item count are the valid ones.
module pair_sum_index_search
	import pssi_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic signed [VALUE_BITS-1:0] cfg_wdata,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  pssi_in_t                     item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output pssi_out_t                    result
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	seq_state_t state_q, state_d;

	logic signed [VALUE_BITS-1:0] target_q;
	logic [CW-1:0]                count_q;
	logic                         pair_done_q;
	logic [CW-1:0]                ptr_q;
	logic [CW-1:0]                idx_q;
	logic [VALUE_BITS:0]          need_q;
	pssi_in_t                     cur_q;
	pssi_out_t                    res_q;
	pssi_out_t                    out_q;
	logic                         out_valid_q;

	logic [CW-1:0]                eff_cnt;
	logic                         eff_pair;
	logic                         accept;
	logic                         go_hold;
	logic                         out_free;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic                         rd_vld;
	logic [AW-1:0]                rd_idx;
	logic signed [VALUE_BITS-1:0] rd_data;
	logic                         match;
	logic                         hit;
	logic                         miss;
	logic [VALUE_BITS:0]          need_d;

	// first flag empties the set before this word is handled
	assign eff_cnt  = item.first_of_set ? '0 : count_q;
	assign eff_pair = item.first_of_set ? 1'b0 : pair_done_q;
	assign accept   = item_valid && item_ready;
	assign go_hold  = eff_pair || (eff_cnt >= CW'(MAX_ITEMS));
	assign out_free = !out_valid_q || result_ready;
	assign need_d   = {target_q[VALUE_BITS-1], target_q}
	                - {item.item_value[VALUE_BITS-1], item.item_value};

	assign rd_en   = (state_q == S_SCAN) && (ptr_q != '0);
	assign rd_addr = AW'(ptr_q - CW'(1));
	assign hit     = (state_q == S_SCAN) && rd_vld && match;
	assign miss    = (state_q == S_SCAN) && !rd_vld && (ptr_q == '0);

	pssi_store #(
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_start(accept),
		.wr_en     (miss),
		.wr_addr   (AW'(idx_q)),
		.wr_data   (cur_q.item_value),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.need      (need_q),
		.rd_vld    (rd_vld),
		.rd_idx    (rd_idx),
		.rd_data   (rd_data),
		.match     (match)
	);

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_d = go_hold ? S_HOLD : S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit || miss) begin
					state_d = S_HOLD;
				end
			end
			S_HOLD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			target_q    <= '0;
			count_q     <= '0;
			pair_done_q <= 1'b0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				target_q <= cfg_wdata;
			end
			if (accept) begin
				// count saturates at capacity
				count_q     <= (eff_cnt < CW'(MAX_ITEMS)) ? CW'(eff_cnt + CW'(1)) : eff_cnt;
				pair_done_q <= eff_pair;
				ptr_q       <= eff_cnt;
			end else if (rd_en) begin
				ptr_q <= CW'(ptr_q - CW'(1));
			end
			if (hit) begin
				pair_done_q <= 1'b1;
			end
			if (result_valid && result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= item;
			idx_q  <= eff_cnt;
			need_q <= need_d;
			res_q.status        <= eff_pair ? ST_IGNORED
			                     : (item.last_of_set ? ST_END : ST_OVER);
			res_q.earlier_index <= '0;
			res_q.current_index <= 8'(eff_cnt);
			res_q.partner_value <= '0;
			res_q.current_value <= item.item_value;
		end
		if (hit) begin
			res_q.status        <= ST_PAIR;
			res_q.earlier_index <= 8'(rd_idx);
			res_q.partner_value <= rd_data;
		end else if (miss) begin
			res_q.status <= cur_q.last_of_set ? ST_END : ST_NONE;
		end
		if (state_q == S_HOLD && out_free) begin
			out_q <= res_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
